FILE: hdl/pdbr_pkg.sv
package pdbr_pkg;

  localparam int unsigned BOARD_CELLS     = 16;
  localparam int unsigned TILE_W          = 4;
  localparam int unsigned CELL_W          = 4;
  localparam int unsigned BOARD_W         = BOARD_CELLS * TILE_W;
  localparam int unsigned TILES_W         = 32;
  localparam int unsigned RANK_W          = 32;
  localparam int unsigned MAX_PATTERN_DEF = 8;
  localparam int unsigned CFG_ADDR_W      = 4;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned SIZE_W          = 4;

  typedef enum logic [1:0] {
    REG_PATTERN_SIZE   = 2'd0,
    REG_TILE_SLOTS     = 2'd1,
    REG_NIBBLE_PACKING = 2'd2,
    REG_NONE           = 2'd3
  } pdbr_reg_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] byte_address;
    logic              high_nibble;
    logic              invalid;
  } pdbr_result_t;

  // P(top, len): product of len descending factors from top, elaboration only
  function automatic logic [RANK_W-1:0] pdbr_fall(int top, int len);
    logic [63:0] p;
    p = 64'd1;
    for (int a = 0; a < len; a++) begin
      p = p * 64'(top - a);
    end
    return p[RANK_W-1:0];
  endfunction

endpackage

FILE: hdl/pdbr_locate.sv
module pdbr_locate #(
  parameter int unsigned MAX_PATTERN = pdbr_pkg::MAX_PATTERN_DEF,
  localparam int unsigned KW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [pdbr_pkg::BOARD_W-1:0]                  board_i,
  input  logic [pdbr_pkg::TILES_W-1:0]                  tiles_i,
  input  logic [KW-1:0]                                 k_i,
  output logic                                          valid_o,
  output logic [MAX_PATTERN-1:0][pdbr_pkg::CELL_W-1:0]  cells_o,
  output logic [pdbr_pkg::CELL_W-1:0]                   blank_o
);
  import pdbr_pkg::*;

  logic                               valid_r;
  logic [MAX_PATTERN-1:0][CELL_W-1:0] cells_r, cells_nxt;
  logic [CELL_W-1:0]                  blank_r, blank_nxt;

  // slot matches only if active, nonzero and first slot naming that tile;
  // the highest cell holding a tile wins
  always_comb begin
    logic [TILE_W-1:0] tile;
    logic              hit;
    for (int i = 0; i < int'(MAX_PATTERN); i++) begin
      tile = tiles_i[TILE_W*i +: TILE_W];
      hit  = (KW'(i) < k_i) && (tile != '0);
      for (int j = 0; j < i; j++) begin
        if (tiles_i[TILE_W*j +: TILE_W] == tile) hit = 1'b0;
      end
      cells_nxt[i] = '0;
      if (hit) begin
        for (int c = 0; c < int'(BOARD_CELLS); c++) begin
          if (board_i[TILE_W*c +: TILE_W] == tile) cells_nxt[i] = CELL_W'(c);
        end
      end
    end
    blank_nxt = '0;
    for (int c = 0; c < int'(BOARD_CELLS); c++) begin
      if (board_i[TILE_W*c +: TILE_W] == '0) blank_nxt = CELL_W'(c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      cells_r <= cells_nxt;
      blank_r <= blank_nxt;
    end
  end

  assign valid_o = valid_r;
  assign cells_o = cells_r;
  assign blank_o = blank_r;

endmodule

FILE: hdl/pdbr_order.sv
module pdbr_order #(
  parameter int unsigned MAX_PATTERN = pdbr_pkg::MAX_PATTERN_DEF,
  localparam int unsigned KW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [MAX_PATTERN-1:0][pdbr_pkg::CELL_W-1:0]  cells_i,
  input  logic [pdbr_pkg::CELL_W-1:0]                   blank_i,
  input  logic [KW-1:0]                                 k_i,
  output logic                                          valid_o,
  output logic [MAX_PATTERN:0][pdbr_pkg::CELL_W-1:0]    below_o,
  output logic                                          bad_o
);
  import pdbr_pkg::*;

  localparam int unsigned N = MAX_PATTERN + 1;

  logic                     valid_r;
  logic [N-1:0][CELL_W-1:0] elem;
  logic [N-1:0][CELL_W-1:0] below_r, below_nxt;
  logic                     bad_r, bad_nxt;

  // element sequence: active pattern cells, then the blank at position k
  always_comb begin
    for (int i = 0; i < int'(N); i++) begin
      if (KW'(i) == k_i) begin
        elem[i] = blank_i;
      end else if (i < int'(MAX_PATTERN)) begin
        elem[i] = cells_i[i];
      end else begin
        elem[i] = '0;
      end
    end
  end

  // unused cells below element i = its cell minus earlier elements below it
  always_comb begin
    logic [CELL_W-1:0] cnt;
    bad_nxt = 1'b0;
    for (int i = 0; i < int'(N); i++) begin
      cnt = '0;
      for (int j = 0; j < i; j++) begin
        if (elem[j] < elem[i]) cnt = cnt + CELL_W'(1);
        if ((elem[j] == elem[i]) && (KW'(i) <= k_i)) bad_nxt = 1'b1;
      end
      below_nxt[i] = (KW'(i) <= k_i) ? elem[i] - cnt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en_i) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      below_r <= below_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign valid_o = valid_r;
  assign below_o = below_r;
  assign bad_o   = bad_r;

endmodule

FILE: hdl/pdbr_accum.sv
module pdbr_accum #(
  parameter int unsigned MAX_PATTERN = pdbr_pkg::MAX_PATTERN_DEF,
  localparam int unsigned KW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  logic [MAX_PATTERN:0][pdbr_pkg::CELL_W-1:0]  below_i,
  input  logic                                        bad_i,
  input  logic [KW-1:0]                               k_i,
  input  logic                                        packing_i,
  output logic                                        valid_o,
  output pdbr_pkg::pdbr_result_t                      res_o
);
  import pdbr_pkg::*;

  localparam int unsigned N  = MAX_PATTERN + 1;
  localparam int unsigned NG = (N + 2) / 3;

  // weight of element i for pattern size kk is P(15 - i, kk - i)
  logic [N-1:0][MAX_PATTERN:0][RANK_W-1:0] wtab;

  for (genvar gi = 0; gi < N; gi++) begin : g_row
    for (genvar gk = 0; gk <= MAX_PATTERN; gk++) begin : g_col
      localparam logic [RANK_W-1:0] WV = (gk >= 1 && gk >= gi) ?
        pdbr_fall(BOARD_CELLS - 1 - gi, gk - gi) : '0;
      assign wtab[gi][gk] = WV;
    end
  end

  logic                     v3_r, v4_r, v5_r;
  logic [N-1:0][RANK_W-1:0] prod_r, prod_nxt;
  logic [NG-1:0][RANK_W-1:0] part_r, part_nxt;
  logic                     bad3_r, bad4_r;
  logic [RANK_W-1:0]        sum;
  pdbr_result_t             res_r, res_nxt;

  always_comb begin
    logic [RANK_W+CELL_W-1:0] p;
    for (int i = 0; i < int'(N); i++) begin
      p = below_i[i] * wtab[i][k_i];
      prod_nxt[i] = p[RANK_W-1:0];
    end
  end

  always_comb begin
    for (int g = 0; g < int'(NG); g++) begin
      part_nxt[g] = '0;
      for (int t = 0; t < 3; t++) begin
        if (3*g + t < int'(N)) part_nxt[g] = part_nxt[g] + prod_r[3*g + t];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < int'(NG); g++) begin
      sum = sum + part_r[g];
    end
    res_nxt.invalid      = bad4_r;
    res_nxt.rank         = bad4_r ? '0 : sum;
    res_nxt.byte_address = packing_i ? {1'b0, res_nxt.rank[RANK_W-1:1]} : res_nxt.rank;
    res_nxt.high_nibble  = packing_i & res_nxt.rank[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en_i) begin
      v3_r <= valid_i;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      prod_r <= prod_nxt;
      bad3_r <= bad_i;
      part_r <= part_nxt;
      bad4_r <= bad3_r;
      res_r  <= res_nxt;
    end
  end

  assign valid_o = v5_r;
  assign res_o   = res_r;

endmodule

FILE: hdl/pdbr_skid.sv
module pdbr_skid (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  input  pdbr_pkg::pdbr_result_t  res_i,
  output logic                    ready_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output pdbr_pkg::pdbr_result_t  res_o
);
  import pdbr_pkg::*;

  logic         ov_r, ov_nxt;
  logic         sv_r, sv_nxt;
  pdbr_result_t od_r, sd_r;
  logic         take, push, load_out, load_skid;

  assign take = ov_r & ready_i;
  assign push = valid_i & ~sv_r;

  always_comb begin
    ov_nxt    = ov_r;
    sv_nxt    = sv_r;
    load_out  = 1'b0;
    load_skid = 1'b0;
    if (sv_r) begin
      if (take) begin
        sv_nxt   = 1'b0;
      end
    end else if (push) begin
      if (!ov_r || take) begin
        load_out = 1'b1;
        ov_nxt   = 1'b1;
      end else begin
        load_skid = 1'b1;
        sv_nxt    = 1'b1;
      end
    end else if (take) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r && take) begin
      od_r <= sd_r;
    end else if (load_out) begin
      od_r <= res_i;
    end
    if (load_skid) begin
      sd_r <= res_i;
    end
  end

  assign ready_o = ~sv_r;
  assign valid_o = ov_r;
  assign res_o   = od_r;

endmodule

FILE: hdl/pattern_db_index_rank_unit.sv
// Pattern database index unit. Each 64-bit board (sixteen 4-bit tiles, cell c
// at bits 4c+3:4c, tile 0 is the blank) is turned into the lexicographic rank of
// the cells holding the configured pattern tiles followed by the blank cell,
// plus the packed-table byte address and nibble select. One board is accepted
// per cycle unless the skid entry is full; a result goes through locate, order,
// multiply and two-level add; a two-entry output buffer keeps in_tready from
// depending on out_tready. Tile 0 in a slot, a tile missing from the board, or
// a missing blank gives cell 0; the highest cell wins on repeats; two ranked
// elements in one cell set the invalid flag with rank, address and nibble 0.
// Registers (write only while no transaction is in flight): 0x0 pattern_size,
// 0x4 tile slots, 0x8 nibble_packing.
module pattern_db_index_rank_unit #(
  parameter int unsigned MAX_PATTERN = pdbr_pkg::MAX_PATTERN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // board
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pdbr_pkg::BOARD_W-1:0]        in_tdata,
  // rank [31:0], byte_address [63:32]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [2*pdbr_pkg::RANK_W-1:0]       out_tdata,
  // high_nibble [0], invalid [1]
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pdbr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pdbr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pdbr_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import pdbr_pkg::*;

  localparam int unsigned KW = $clog2(MAX_PATTERN + 1);

  logic [SIZE_W-1:0]  size_r;
  logic [TILES_W-1:0] tiles_r;
  logic               packing_r;
  pdbr_reg_t          reg_sel;
  logic               wr_en;
  logic [KW-1:0]      k;
  logic               adv;

  assign cfg_pready = 1'b1;
  assign reg_sel    = pdbr_reg_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= SIZE_W'(1);
      tiles_r   <= '0;
      packing_r <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_SIZE:   size_r    <= cfg_pwdata[SIZE_W-1:0];
        REG_TILE_SLOTS:     tiles_r   <= cfg_pwdata[TILES_W-1:0];
        REG_NIBBLE_PACKING: packing_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_SIZE:   cfg_prdata = CFG_DATA_W'(size_r);
      REG_TILE_SLOTS:     cfg_prdata = CFG_DATA_W'(tiles_r);
      REG_NIBBLE_PACKING: cfg_prdata = CFG_DATA_W'(packing_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // clamp pattern size to 1..MAX_PATTERN
  always_comb begin
    if (size_r == '0) begin
      k = KW'(1);
    end else if (size_r > SIZE_W'(MAX_PATTERN)) begin
      k = KW'(MAX_PATTERN);
    end else begin
      k = size_r[KW-1:0];
    end
  end

  logic                               v1, v2, v5;
  logic [MAX_PATTERN-1:0][CELL_W-1:0] cells;
  logic [CELL_W-1:0]                  blank;
  logic [MAX_PATTERN:0][CELL_W-1:0]   below;
  logic                               bad;
  pdbr_result_t                       res, res_out;

  pdbr_locate #(.MAX_PATTERN(MAX_PATTERN)) u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (adv),
    .valid_i (in_tvalid),
    .board_i (in_tdata),
    .tiles_i (tiles_r),
    .k_i     (k),
    .valid_o (v1),
    .cells_o (cells),
    .blank_o (blank)
  );

  pdbr_order #(.MAX_PATTERN(MAX_PATTERN)) u_order (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (adv),
    .valid_i (v1),
    .cells_i (cells),
    .blank_i (blank),
    .k_i     (k),
    .valid_o (v2),
    .below_o (below),
    .bad_o   (bad)
  );

  pdbr_accum #(.MAX_PATTERN(MAX_PATTERN)) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en_i      (adv),
    .valid_i   (v2),
    .below_i   (below),
    .bad_i     (bad),
    .k_i       (k),
    .packing_i (packing_r),
    .valid_o   (v5),
    .res_o     (res)
  );

  pdbr_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v5),
    .res_i   (res),
    .ready_o (adv),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .res_o   (res_out)
  );

  assign in_tready = adv;
  assign out_tdata = {res_out.byte_address, res_out.rank};
  assign out_tuser = {res_out.invalid, res_out.high_nibble};

endmodule

FILE: tb/pattern_db_index_rank_unit_test.sv
`timescale 1ns / 1ps

module pattern_db_index_rank_unit_test;
  import pdbr_pkg::*;

  localparam int MAX_TILES     = MAX_PATTERN_DEF;
  localparam int LATENCY       = 5;
  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BOARDS  = 50;
  localparam int NUM_DIRECTED  = 19;
  localparam int RING_DEPTH    = 64;

  typedef struct packed {
    logic [3:0]   size;
    logic [31:0]  tiles;
    logic         packing;
    logic [63:0]  board;
    logic         known;
    pdbr_result_t want;
  } board_case_t;

  // settings, board, and the result where it is obvious (known = 1)
  localparam board_case_t DIRECTED_BOARDS [NUM_DIRECTED] = '{
    // reset settings: slot 0 holds tile 0, so rank = blank cell - 1 (invalid if the blank is in cell 0)
    '{4'd1, 32'h0, 1'b1, 64'h0000_0000_0000_0000, 1'b1, '{32'd14, 32'd7, 1'b0, 1'b0}},
    '{4'd1, 32'h0, 1'b1, 64'h1111_1111_1111_1111, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
    '{4'd1, 32'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
    '{4'd1, 32'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FF0F, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{4'd1, 32'h0, 1'b1, 64'hFFFF_FFFF_FFFF_F0FF, 1'b1, '{32'd1, 32'd0, 1'b1, 1'b0}},
    '{4'd1, 32'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
    // byte per entry
    '{4'd1, 32'h0, 1'b0, 64'h0000_0000_0000_0000, 1'b1, '{32'd14, 32'd14, 1'b0, 1'b0}},
    '{4'd1, 32'h0, 1'b0, 64'hFFFF_FFFF_FFFF_F0FF, 1'b1, '{32'd1, 32'd1, 1'b0, 1'b0}},
    // full pattern: identity, reversed, top rank, all blanks
    '{4'd8, 32'h8765_4321, 1'b0, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
    '{4'd8, 32'h8765_4321, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
    '{4'd8, 32'h8765_4321, 1'b0, 64'h1234_5678_09AB_CDEF, 1'b0, '0},
    '{4'd8, 32'h8765_4321, 1'b0, 64'h0000_0000_0000_0000, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
    '{4'd8, 32'h8765_4321, 1'b1, 64'h1234_5678_09AB_CDEF, 1'b0, '0},
    // tile 3 twice on the board, tile 5 missing
    '{4'd8, 32'h8765_4321, 1'b1, 64'h1234_3678_09AB_CDEF, 1'b0, '0},
    // size 0 acts as 1, size 15 acts as 8
    '{4'd0, 32'h0000_0001, 1'b1, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
    '{4'd15, 32'hFEDC_BA98, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
    '{4'd15, 32'hFEDC_BA98, 1'b0, 64'h9F3A_0C5E_7D1B_2684, 1'b0, '0},
    // same tile in two slots; tile 0 in a slot
    '{4'd2, 32'h0000_0033, 1'b1, 64'h0EDC_BA98_7654_321F, 1'b0, '0},
    '{4'd4, 32'h0000_3103, 1'b1, 64'hFEDC_BA98_7654_3210, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BOARD_W-1:0]    in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2*RANK_W-1:0]   out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // register copies used by the rank predictor
  logic [3:0]  size_reg = 4'd1;
  logic [31:0] tiles_reg = 32'h0;
  logic        packing_reg = 1'b1;

  // expected results in order of acceptance
  pdbr_result_t pending_ranks [RING_DEPTH];
  int rank_wr = 0;
  int rank_rd = 0;
  int error_count = 0;
  int ranks_checked = 0;
  int invalid_seen = 0;
  int boards_sent = 0;
  int settings_applied = 0;
  int cycle_count = 0;
  bit sender_smooth = 1'b0;
  bit sink_smooth = 1'b0;
  bit hold_off_req = 1'b0;
  int sink_wait = 0;

  pattern_db_index_rank_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d ranks outstanding", cycle_count,
               rank_wr - rank_rd);
      $display("** pattern_db_index_rank_unit: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 40) begin
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    end
  endtask

  // Partial permutation rank of (pattern cells..., blank cell) under current settings
  function automatic pdbr_result_t rank_board(input logic [63:0] board);
    int k, m, blank_cell, below, x;
    int cells [MAX_TILES+1];
    logic [15:0] taken;
    logic [63:0] acc, weight;
    logic [3:0] tile;
    logic found, clash;
    pdbr_result_t r;
    k = (size_reg == 4'd0) ? 1 : ((size_reg > MAX_TILES) ? MAX_TILES : int'(size_reg));
    m = k + 1;
    blank_cell = 0;
    taken = '0;
    acc = '0;
    clash = 1'b0;
    for (int i = 0; i <= MAX_TILES; i++) cells[i] = 0;
    for (int c = 0; c < BOARD_CELLS; c++) begin
      tile = board[4*c +: 4];
      if (tile == 4'd0) begin
        blank_cell = c;
      end else begin
        // lowest matching slot only; later cells overwrite earlier ones
        found = 1'b0;
        for (int i = 0; i < k; i++) begin
          if (!found && tiles_reg[4*i +: 4] == tile) begin
            cells[i] = c;
            found = 1'b1;
          end
        end
      end
    end
    cells[k] = blank_cell;
    for (int i = 0; i < m; i++) begin
      x = cells[i];
      if (!clash) begin
        if (taken[x]) begin
          clash = 1'b1;
        end else begin
          below = 0;
          for (int b = 0; b < x; b++) if (!taken[b]) below++;
          weight = 64'd1;
          for (int a = 0; a < m - 1 - i; a++) weight = weight * 64'(15 - i - a);
          acc = acc + 64'(below) * weight;
          taken[x] = 1'b1;
        end
      end
    end
    r.rank = clash ? '0 : acc[31:0];
    r.byte_address = packing_reg ? {1'b0, r.rank[31:1]} : r.rank;
    r.high_nibble = packing_reg & r.rank[0];
    r.invalid = clash;
    return r;
  endfunction

  function automatic logic [63:0] shuffled_board();
    logic [3:0] cell_tile [16];
    logic [3:0] swap;
    logic [63:0] b;
    int j;
    for (int c = 0; c < 16; c++) cell_tile[c] = 4'(c);
    for (int c = 15; c > 0; c--) begin
      j = $urandom_range(0, c);
      swap = cell_tile[c];
      cell_tile[c] = cell_tile[j];
      cell_tile[j] = swap;
    end
    for (int c = 0; c < 16; c++) b[4*c +: 4] = cell_tile[c];
    return b;
  endfunction

  // eight distinct nonzero tiles in random order
  function automatic logic [31:0] distinct_tiles();
    logic [63:0] b;
    logic [31:0] t;
    int n;
    b = shuffled_board();
    t = '0;
    n = 0;
    for (int c = 0; c < 16; c++) begin
      if (b[4*c +: 4] != 4'd0 && n < MAX_TILES) begin
        t[4*n +: 4] = b[4*c +: 4];
        n++;
      end
    end
    return t;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 70) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_board(input logic [63:0] board, input logic use_given,
                            input pdbr_result_t given);
    in_tdata <= board;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_ranks[rank_wr % RING_DEPTH] = use_given ? given : rank_board(board);
    rank_wr++;
    boards_sent++;
    @(negedge clk);
  endtask

  task automatic sender_pause(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_idle();
    sender_pause(1);
    while (rank_wr != rank_rd) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic cfg_access(input pdbr_reg_t sel, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_reg(input pdbr_reg_t sel, input logic [31:0] value,
                           input logic [31:0] mask);
    logic [31:0] rd;
    cfg_access(sel, 1'b1, value, rd);
    cfg_access(sel, 1'b0, 32'h0, rd);
    if (rd !== (value & mask)) report_mismatch($sformatf("readback %s", sel.name()),
                                               64'(rd), 64'(value & mask));
  endtask

  task automatic apply_settings(input logic [3:0] sz, input logic [31:0] tl, input logic pk);
    logic [31:0] junk;
    wait_idle();
    junk = $urandom;
    // upper data bits are don't-care for the narrow registers
    write_reg(REG_PATTERN_SIZE, {junk[31:4], sz}, 32'h0000_000F);
    write_reg(REG_TILE_SLOTS, tl, 32'hFFFF_FFFF);
    write_reg(REG_NIBBLE_PACKING, {junk[30:0], pk}, 32'h0000_0001);
    size_reg = sz;
    tiles_reg = tl;
    packing_reg = pk;
    settings_applied++;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (sink_smooth) begin
        out_tready <= 1'b1;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        sink_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    pdbr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rank_wr == rank_rd) begin
        report_mismatch("result with nothing pending", out_tdata, 64'h0);
      end else begin
        want = pending_ranks[rank_rd % RING_DEPTH];
        rank_rd++;
        ranks_checked++;
        if (out_tuser[1]) invalid_seen++;
        if (out_tdata[31:0] !== want.rank)
          report_mismatch("rank", 64'(out_tdata[31:0]), 64'(want.rank));
        if (out_tdata[63:32] !== want.byte_address)
          report_mismatch("byte_address", 64'(out_tdata[63:32]), 64'(want.byte_address));
        if (out_tuser[0] !== want.high_nibble)
          report_mismatch("high_nibble", 64'(out_tuser[0]), 64'(want.high_nibble));
        if (out_tuser[1] !== want.invalid)
          report_mismatch("invalid", 64'(out_tuser[1]), 64'(want.invalid));
      end
    end
  end

  initial begin : stimulus
    logic [63:0] board;
    logic [3:0] sz;
    logic [31:0] tl;
    int pick, gap;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int n = 0; n < NUM_DIRECTED; n++) begin
      if (DIRECTED_BOARDS[n].size != size_reg || DIRECTED_BOARDS[n].tiles != tiles_reg ||
          DIRECTED_BOARDS[n].packing != packing_reg) begin
        apply_settings(DIRECTED_BOARDS[n].size, DIRECTED_BOARDS[n].tiles,
                       DIRECTED_BOARDS[n].packing);
      end
      send_board(DIRECTED_BOARDS[n].board, DIRECTED_BOARDS[n].known, DIRECTED_BOARDS[n].want);
      gap = idle_len();
      if (gap > 0) sender_pause(gap);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: sz = 4'd8;
        1: sz = 4'd0;
        2: sz = 4'd15;
        3: sz = 4'd1;
        default: sz = 4'($urandom_range(0, 15));
      endcase
      tl = (p % 4 == 3) ? 32'($urandom) : distinct_tiles();
      apply_settings(sz, tl, (p % 2) == 0);
      sender_smooth = (p == 1 || p == 4);
      sink_smooth = (p == 4);
      // back up the output while boards keep coming
      if (p == 1) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_BOARDS; n++) begin
        pick = $urandom_range(0, 99);
        board = shuffled_board();
        if (pick >= 90) begin
          board = {32'($urandom), 32'($urandom)};
        end else if (pick >= 80) begin
          board[4*$urandom_range(0, 15) +: 4] = 4'($urandom_range(0, 15));
        end
        send_board(board, 1'b0, '0);
        gap = sender_smooth ? 0 : idle_len();
        if (gap > 0) sender_pause(gap);
      end
    end

    sender_smooth = 1'b0;
    sink_smooth = 1'b1;
    wait_idle();
    $display("sent %0d boards (%0d directed) under %0d register settings",
             boards_sent, NUM_DIRECTED, settings_applied);
    $display("checked %0d ranks, %0d of them flagged invalid", ranks_checked, invalid_seen);
    if (error_count == 0 && rank_wr == rank_rd) begin
      $display("** pattern_db_index_rank_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d ranks never returned", error_count, rank_wr - rank_rd);
      $display("** pattern_db_index_rank_unit: FAILED **");
    end
    $finish;
  end

endmodule
